>>> sv/pagerank_power_iteration_core_defines.svh
// assertion macros for the pagerank power iteration core
// used by the top level only, needs clk and rst in scope
`ifndef PAGERANK_POWER_ITERATION_CORE_DEFINES_SVH
`define PAGERANK_POWER_ITERATION_CORE_DEFINES_SVH

// property that holds at every edge outside reset
`define PGR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent this cycle implies consequent next cycle
`define PGR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/pgr_pkg.sv
// package for the pagerank power iteration core
// types, constants and sequencer states, no dependencies
`default_nettype none
package pgr_pkg;

  localparam int MAX_PAGES_DEF = 32;
  localparam int ENTRY_W       = 17;
  localparam int RANK_W        = 32;
  localparam int ACC_W         = 54;
  localparam int PROD_W        = ENTRY_W + RANK_W;
  localparam int CHANGE_W      = 40;
  localparam int TOTAL_W       = 37;
  localparam int QUOT_W        = 17;
  localparam int CFG_W         = 32;
  localparam int CFG_IDX_W     = 2;

  localparam logic [RANK_W-1:0] RANK_ONE = 32'h0001_0000;
  localparam logic [RANK_W-1:0] RANK_SAT = 32'hFFFF_FFFF;

  localparam logic [CFG_IDX_W-1:0] REG_PAGE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT = 2'd2;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_START = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_INIT, ST_MRD, ST_MMUL, ST_MACC, ST_MWR,
    ST_DRD, ST_DACC, ST_CHECK, ST_NRD, ST_NLD, ST_NDIV, ST_NOUT
  } state_t;

  typedef struct packed {
    logic                done;
    logic [QUOT_W-1:0]   quotient;
  } div_stat_t;

endpackage
`default_nettype wire

>>> sv/pgr_if.sv
// stream interfaces for the pagerank power iteration core
// input words and result words, no dependencies
`default_nettype none
interface pgr_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [4:0]  row_index;
  logic [4:0]  col_index;
  logic [16:0] entry_value;
  modport source(output valid, action, row_index, col_index, entry_value, input ready);
  modport sink(input valid, action, row_index, col_index, entry_value, output ready);
endinterface

interface pgr_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  page_index;
  logic [16:0] rank_value;
  logic        converged;
  logic        last;
  modport source(output valid, page_index, rank_value, converged, last, input ready);
  modport sink(input valid, page_index, rank_value, converged, last, output ready);
endinterface
`default_nettype wire

>>> sv/pagerank_power_iteration_core.sv
// pagerank power iteration core, top level
// depends on pgr_pkg, pgr_if, pgr_div and the assertion macro header
//
// usage: load words (action 0) write one matrix entry each. a start word
// (action 1) sets every rank to 1.0 and repeats the matrix-vector product
// until the summed rank change is not above threshold or the pass limit is
// reached, then emits page_count result words, capped at MAX_PAGES, last
// one marked. a single 17x32 multiply-accumulate unit does all products,
// each matrix entry passing through the read, multiply and accumulate states.
// normalization uses a bit serial divider for each result word; the
// quotient is zero when the rank sum is zero.
// in_ch.ready is high only while idle; the block handles one word at a time.
// results sit in an output register; while out_ch.ready is low the block
// waits and holds the word. configuration writes are taken at any time but
// belong between words. synchronous reset returns the sequencer to idle and
// restores register defaults; the matrix holds its contents undefined.
`default_nettype none
`include "pagerank_power_iteration_core_defines.svh"
module pagerank_power_iteration_core
  import pgr_pkg::*;
#(
  parameter int MAX_PAGES = MAX_PAGES_DEF
)(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_wen,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  pgr_in_if.sink                    in_ch,
  pgr_out_if.source                 out_ch
);

  localparam int CAP = (MAX_PAGES < 32) ? MAX_PAGES : 32;
  localparam int CW  = $clog2(CAP + 1);
  localparam int AW  = $clog2(MAX_PAGES);
  localparam int MW  = $clog2(MAX_PAGES * MAX_PAGES);

  logic [5:0]          page_count;
  logic [31:0]         threshold;
  logic [15:0]         iteration_limit;

  state_t              state, state_next;
  logic [CW-1:0]       i, j, n_act;
  logic [15:0]         pass_count;
  logic [ACC_W-1:0]    acc;
  logic [PROD_W-1:0]   prod;
  logic [CHANGE_W-1:0] change_sum;
  logic [TOTAL_W-1:0]  total;
  logic                conv;

  logic [ENTRY_W-1:0]  trans_mem [MAX_PAGES*MAX_PAGES];
  logic [RANK_W-1:0]   rank_mem  [MAX_PAGES];
  logic [RANK_W-1:0]   next_mem  [MAX_PAGES];
  logic [ENTRY_W-1:0]  trans_q;
  logic [RANK_W-1:0]   rank_q, next_q;

  logic                in_fire, out_fire, load_we, load_ok;
  logic                i_last, j_last, done_pass;
  logic [MW-1:0]       load_addr, mat_addr;
  logic [AW-1:0]       rank_raddr;
  logic                rank_we;
  logic [RANK_W-1:0]   rank_wdata, sat_val, diff;
  logic [15:0]         pass_inc;
  logic                div_start;
  div_stat_t           div_stat;

  logic                out_valid, out_conv, out_last;
  logic [4:0]          out_page;
  logic [QUOT_W-1:0]   out_rank;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      page_count      <= 6'd4;
      threshold       <= 32'd66;
      iteration_limit <= 16'd1000;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_PAGE_COUNT: page_count      <= cfg_data[5:0];
        REG_THRESHOLD:  threshold       <= cfg_data;
        REG_ITER_LIMIT: iteration_limit <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign n_act     = (32'(page_count) > CAP) ? CW'(CAP) : CW'(page_count);
  assign in_fire   = in_ch.valid && in_ch.ready;
  assign out_fire  = out_ch.valid && out_ch.ready;
  assign i_last    = (i + CW'(1)) == n_act;
  assign j_last    = (j + CW'(1)) == n_act;
  assign load_ok   = (32'(in_ch.row_index) < MAX_PAGES) && (32'(in_ch.col_index) < MAX_PAGES);
  assign load_we   = in_fire && (in_ch.action == ACT_LOAD) && load_ok;
  assign load_addr = MW'(MW'(in_ch.row_index) * MW'(MAX_PAGES) + MW'(in_ch.col_index));
  assign mat_addr  = MW'(MW'(i) * MW'(MAX_PAGES) + MW'(j));
  assign sat_val   = (|acc[ACC_W-1:48]) ? RANK_SAT : acc[47:16];
  assign diff      = (next_q > rank_q) ? next_q - rank_q : rank_q - next_q;
  assign pass_inc  = pass_count + 16'd1;
  assign done_pass = (change_sum <= {8'd0, threshold}) || (pass_inc >= iteration_limit);

  // memories
  always_ff @(posedge clk) begin
    if (load_we) trans_mem[load_addr] <= in_ch.entry_value;
    trans_q <= trans_mem[mat_addr];
  end

  always_ff @(posedge clk) begin
    if (rank_we) rank_mem[AW'(i)] <= rank_wdata;
    rank_q <= rank_mem[rank_raddr];
  end

  always_ff @(posedge clk) begin
    if (state == ST_MWR) next_mem[AW'(i)] <= sat_val;
    next_q <= next_mem[AW'(i)];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_fire && in_ch.action == ACT_START && n_act != '0) state_next = ST_INIT;
      ST_INIT:  if (i_last) state_next = ST_MRD;
      ST_MRD:   state_next = ST_MMUL;
      ST_MMUL:  state_next = ST_MACC;
      ST_MACC:  state_next = j_last ? ST_MWR : ST_MRD;
      ST_MWR:   state_next = i_last ? ST_DRD : ST_MRD;
      ST_DRD:   state_next = ST_DACC;
      ST_DACC:  state_next = i_last ? ST_CHECK : ST_DRD;
      ST_CHECK: state_next = done_pass ? ST_NRD : ST_MRD;
      ST_NRD:   state_next = ST_NLD;
      ST_NLD:   state_next = ST_NDIV;
      ST_NDIV:  if (div_stat.done) state_next = ST_NOUT;
      ST_NOUT:  if (out_fire) state_next = i_last ? ST_IDLE : ST_NRD;
      default:  state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ch.ready = 1'b0;
    out_valid   = 1'b0;
    rank_we     = 1'b0;
    rank_wdata  = next_q;
    rank_raddr  = AW'(i);
    div_start   = 1'b0;
    case (state)
      ST_IDLE: in_ch.ready = 1'b1;
      ST_INIT: begin
        rank_we    = 1'b1;
        rank_wdata = RANK_ONE;
      end
      ST_MRD:  rank_raddr = AW'(j);
      ST_DACC: rank_we = 1'b1;
      ST_NLD:  div_start = 1'b1;
      ST_NOUT: out_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pass_count <= '0;
      change_sum <= '0;
      i          <= '0;
      j          <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          i <= '0;
          j <= '0;
        end
        ST_INIT: begin
          if (i_last) begin
            i          <= '0;
            j          <= '0;
            acc        <= '0;
            pass_count <= '0;
          end else begin
            i <= i + CW'(1);
          end
        end
        ST_MMUL: prod <= PROD_W'(trans_q) * PROD_W'(rank_q);
        ST_MACC: begin
          acc <= acc + ACC_W'(prod);
          if (!j_last) j <= j + CW'(1);
        end
        ST_MWR: begin
          acc <= '0;
          j   <= '0;
          if (i_last) begin
            i          <= '0;
            change_sum <= '0;
            total      <= '0;
          end else begin
            i <= i + CW'(1);
          end
        end
        ST_DACC: begin
          change_sum <= change_sum + CHANGE_W'(diff);
          total      <= total + TOTAL_W'(next_q);
          if (!i_last) i <= i + CW'(1);
        end
        ST_CHECK: begin
          pass_count <= pass_inc;
          conv       <= change_sum <= {8'd0, threshold};
          i          <= '0;
          j          <= '0;
          acc        <= '0;
        end
        ST_NDIV: begin
          if (div_stat.done) begin
            out_rank <= div_stat.quotient;
            out_page <= 5'(i);
            out_last <= i_last;
            out_conv <= conv;
          end
        end
        ST_NOUT: if (out_fire && !i_last) i <= i + CW'(1);
        default: ;
      endcase
    end
  end

  pgr_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (rank_q),
    .den   (total),
    .stat  (div_stat)
  );

  assign out_ch.valid      = out_valid;
  assign out_ch.page_index = out_page;
  assign out_ch.rank_value = out_rank;
  assign out_ch.converged  = out_conv;
  assign out_ch.last       = out_last;

  `PGR_ASSERT(a_one_side, !(in_ch.ready && out_ch.valid), "input taken while a result waits")
  `PGR_ASSERT(a_rank_range, !out_ch.valid || (out_ch.rank_value <= 17'h10000), "rank above one")
  `PGR_ASSERT_NEXT(a_last_idle, out_ch.valid && out_ch.ready && out_ch.last, in_ch.ready, "not idle after last word")

endmodule
`default_nettype wire

>>> sv/pgr_div.sv
// bit serial divider for rank normalization, one quotient bit a cycle
// depends on pgr_pkg
`default_nettype none
module pgr_div
  import pgr_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [RANK_W-1:0]  num,
  input  wire logic [TOTAL_W-1:0] den,
  output div_stat_t               stat
);

  logic                active;
  logic [4:0]          cnt;
  logic [TOTAL_W-1:0]  rem;
  logic [QUOT_W-1:0]   quot;
  logic                done;
  logic [TOTAL_W:0]    rem2;
  logic                bit_set;
  logic                first_ge;

  assign rem2     = {rem, 1'b0};
  assign bit_set  = rem2 >= {1'b0, den};
  assign first_ge = TOTAL_W'(num) >= den;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (den == '0) begin
          active <= 1'b0;
          done   <= 1'b1;
        end else begin
          active <= 1'b1;
          cnt    <= 5'd16;
        end
      end else if (active) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      if (den == '0) begin
        quot <= '0;
        rem  <= '0;
      end else begin
        quot <= QUOT_W'(first_ge);
        rem  <= first_ge ? TOTAL_W'(TOTAL_W'(num) - den) : TOTAL_W'(num);
      end
    end else if (active) begin
      quot <= {quot[QUOT_W-2:0], bit_set};
      rem  <= bit_set ? TOTAL_W'(rem2 - {1'b0, den}) : TOTAL_W'(rem2);
    end
  end

  assign stat.done     = done;
  assign stat.quotient = quot;

endmodule
`default_nettype wire
